// File: rtl/gbnr_pkg.sv
package gbnr_pkg;

  // Default depth of the command queue between parser and verdict stage
  localparam int QUEUE_DEPTH = 4;

  // Frame parse phases
  typedef enum logic [1:0] {
    PH_SEQ  = 2'd0,
    PH_LEN  = 2'd1,
    PH_DATA = 2'd2,
    PH_SUM  = 2'd3
  } phase_t;

  // Result kinds on the output channel
  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_ACK     = 2'd1,
    KIND_REACK   = 2'd2,
    KIND_BAD     = 2'd3
  } kind_t;

  // Command classes handed from the parser to the verdict stage
  typedef enum logic {
    CMD_PAYLOAD = 1'b0,
    CMD_CHECK   = 1'b1
  } cmd_op_t;

  // One queued command
  typedef struct packed {
    cmd_op_t    op;
    logic [7:0] data;
    logic [7:0] seq;
    logic       sum_ok;
  } cmd_t;

  // Queue status seen by the parser and the verdict stage
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

// File: rtl/gbnr_queue.sv
module gbnr_queue #(
  parameter int DEPTH = gbnr_pkg::QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  gbnr_pkg::cmd_t      push_cmd,
  input  logic                pop,
  output gbnr_pkg::cmd_t      pop_cmd,
  output gbnr_pkg::q_status_t status
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  gbnr_pkg::cmd_t mem_r [DEPTH];
  logic [PW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]  count_r, count_nxt;
  logic           do_push, do_pop;

  assign status.full  = (count_r == FULL_CNT);
  assign status.empty = (count_r == '0);
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;
  assign pop_cmd      = mem_r[rd_ptr_r];

  // Advance pointers with wrap and track fill level
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store the pushed command
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

// File: rtl/gbnr_front.sv
module gbnr_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic [7:0]          in_byte,
  input  logic                in_start,
  output logic                in_ready,
  input  gbnr_pkg::q_status_t q_status,
  output logic                q_push,
  output gbnr_pkg::cmd_t      q_cmd
);

  gbnr_pkg::phase_t phase_r, phase_nxt;
  logic [7:0]       frame_seq_r, frame_seq_nxt;
  logic [7:0]       bytes_left_r, bytes_left_nxt;
  logic [7:0]       running_sum_r, running_sum_nxt;
  logic [7:0]       left_dec;
  logic             accept;

  assign in_ready = !q_status.full;
  assign accept   = in_valid && !q_status.full;
  assign left_dec = bytes_left_r - 8'd1;

  // Next parse phase
  always_comb begin
    phase_nxt = phase_r;
    if (accept) begin
      if (in_start) begin
        phase_nxt = gbnr_pkg::PH_LEN;
      end else begin
        unique case (phase_r)
          gbnr_pkg::PH_SEQ:  phase_nxt = gbnr_pkg::PH_SEQ;
          gbnr_pkg::PH_LEN:  phase_nxt = (in_byte == 8'd0) ? gbnr_pkg::PH_SUM
                                                           : gbnr_pkg::PH_DATA;
          gbnr_pkg::PH_DATA: phase_nxt = (left_dec == 8'd0) ? gbnr_pkg::PH_SUM
                                                            : gbnr_pkg::PH_DATA;
          gbnr_pkg::PH_SUM:  phase_nxt = gbnr_pkg::PH_SEQ;
          default:           phase_nxt = gbnr_pkg::PH_SEQ;
        endcase
      end
    end
  end

  // Frame datapath and command generation
  always_comb begin
    frame_seq_nxt   = frame_seq_r;
    bytes_left_nxt  = bytes_left_r;
    running_sum_nxt = running_sum_r;
    q_push          = 1'b0;
    q_cmd.op        = gbnr_pkg::CMD_PAYLOAD;
    q_cmd.data      = in_byte;
    q_cmd.seq       = frame_seq_r;
    q_cmd.sum_ok    = (in_byte == running_sum_r);
    if (accept) begin
      if (in_start) begin
        frame_seq_nxt   = in_byte;
        running_sum_nxt = in_byte;
        bytes_left_nxt  = 8'd0;
      end else begin
        unique case (phase_r)
          gbnr_pkg::PH_SEQ: begin
          end
          gbnr_pkg::PH_LEN: begin
            bytes_left_nxt  = in_byte;
            running_sum_nxt = running_sum_r + in_byte;
          end
          gbnr_pkg::PH_DATA: begin
            bytes_left_nxt  = left_dec;
            running_sum_nxt = running_sum_r + in_byte;
            q_push          = 1'b1;
          end
          gbnr_pkg::PH_SUM: begin
            q_cmd.op = gbnr_pkg::CMD_CHECK;
            q_push   = 1'b1;
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= gbnr_pkg::PH_SEQ;
      frame_seq_r   <= '0;
      bytes_left_r  <= '0;
      running_sum_r <= '0;
    end else begin
      phase_r       <= phase_nxt;
      frame_seq_r   <= frame_seq_nxt;
      bytes_left_r  <= bytes_left_nxt;
      running_sum_r <= running_sum_nxt;
    end
  end

endmodule

// File: rtl/gbnr_back.sv
module gbnr_back (
  input  logic                clk,
  input  logic                rst_n,
  input  gbnr_pkg::q_status_t q_status,
  input  gbnr_pkg::cmd_t      q_cmd,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_ready,
  output gbnr_pkg::kind_t     out_kind,
  output logic [7:0]          out_value
);

  logic [7:0]      expected_r, expected_nxt;
  logic            out_valid_r, out_valid_nxt;
  gbnr_pkg::kind_t kind_r, kind_nxt;
  logic [7:0]      value_r, value_nxt;

  assign q_pop     = !q_status.empty && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;
  assign out_kind  = kind_r;
  assign out_value = value_r;

  // Decide the result for the command at the queue head
  always_comb begin
    expected_nxt  = expected_r;
    kind_nxt      = kind_r;
    value_nxt     = value_r;
    out_valid_nxt = out_valid_r && !out_ready;
    if (q_pop) begin
      out_valid_nxt = 1'b1;
      unique case (q_cmd.op)
        gbnr_pkg::CMD_PAYLOAD: begin
          kind_nxt  = gbnr_pkg::KIND_PAYLOAD;
          value_nxt = q_cmd.data;
        end
        gbnr_pkg::CMD_CHECK: begin
          if (!q_cmd.sum_ok) begin
            kind_nxt  = gbnr_pkg::KIND_BAD;
            value_nxt = q_cmd.seq;
          end else if (q_cmd.seq == expected_r) begin
            kind_nxt     = gbnr_pkg::KIND_ACK;
            value_nxt    = q_cmd.seq;
            expected_nxt = expected_r + 8'd1;
          end else begin
            kind_nxt  = gbnr_pkg::KIND_REACK;
            value_nxt = expected_r - 8'd1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      expected_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      expected_r  <= expected_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Hold the result until it is taken
  always_ff @(posedge clk) begin
    kind_r  <= kind_nxt;
    value_r <= value_nxt;
  end

endmodule

// File: rtl/go_back_n_frame_receiver.sv
// Go-back-N frame receiver.
// Input stream: one frame byte per transaction. A frame is a sequence byte
// (flagged by in_tuser), a length byte, that many payload bytes and a
// checksum byte equal to the 8-bit sum of all earlier frame bytes.
// Output stream: one result per payload byte and one per checksum byte;
// out_tuser gives the kind (payload, ACK, re-ACK of expected-1, discard),
// out_tdata the payload byte or sequence number.
// Throughput: one byte per cycle sustained while in_tready is high; the parser,
// the command queue and the verdict stage each take one transaction per cycle,
// the verdict stage while its output is free or taken. A command is queued
// when its byte is accepted; its result is then registered at the output.
// Reset (rst_n low, synchronous) empties the queue, drops any pending result,
// returns the parser to waiting for a sequence byte and clears the expected
// sequence number. When out_tready is low the output register holds its
// result; the queue absorbs up to QUEUE_DEPTH commands, after which
// in_tready drops.
module go_back_n_frame_receiver #(
  parameter int QUEUE_DEPTH = gbnr_pkg::QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] rx_byte
  input  logic [0:0] in_tuser,   // [0] frame_start
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] value
  output logic [1:0] out_tuser   // [1:0] kind
);

  gbnr_pkg::q_status_t q_status;
  gbnr_pkg::cmd_t      push_cmd, pop_cmd;
  logic                q_push, q_pop;
  gbnr_pkg::kind_t     kind;

  gbnr_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_byte  (in_tdata),
    .in_start (in_tuser[0]),
    .in_ready (in_tready),
    .q_status (q_status),
    .q_push   (q_push),
    .q_cmd    (push_cmd)
  );

  gbnr_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (push_cmd),
    .pop      (q_pop),
    .pop_cmd  (pop_cmd),
    .status   (q_status)
  );

  gbnr_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_status  (q_status),
    .q_cmd     (pop_cmd),
    .q_pop     (q_pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_kind  (kind),
    .out_value (out_tdata)
  );

  assign out_tuser = kind;

endmodule
